// File: rtl/arcp_pkg.sv
// package for the abacus row cluster placer
// constants, command and status types shared by controller and datapath
package arcp_pkg;

  localparam int unsigned MaxCellsDef = 64;
  localparam int unsigned FracBitsDef = 8;
  localparam int unsigned CoordW      = 20;
  localparam int unsigned IdxOutW     = 6;
  localparam int unsigned LegalXW     = 22;
  localparam int unsigned CfgIdxW     = 1;

  localparam logic [CfgIdxW-1:0] CfgSubrowLeft  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSubrowRight = 1'b1;

  localparam logic KindClear = 1'b0;
  localparam logic KindAdd   = 1'b1;

  typedef enum logic [3:0] {
    CmdNone   = 4'd0,
    CmdClear  = 4'd1,
    CmdLoad   = 4'd2,
    CmdRdTop  = 4'd3,
    CmdInsert = 4'd4,
    CmdDivGo  = 4'd5,
    CmdPlace  = 4'd6,
    CmdRdPrev = 4'd7,
    CmdMerge  = 4'd8,
    CmdEmitGo = 4'd9,
    CmdEmitNx = 4'd10
  } cmd_e;

  typedef struct packed {
    logic full;
    logic new_cluster;
    logic div_done;
    logic overlap;
    logic at_bottom;
    logic emit_last;
  } stat_t;

endpackage

// File: rtl/arcp_datapath.sv
// datapath of the abacus row cluster placer: cluster stack memories,
// serial divider, clamp and emit arithmetic; uses arcp_pkg
module arcp_datapath import arcp_pkg::*; #(
  parameter int unsigned MaxCells = MaxCellsDef,
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_e                cmd_i,
  input  logic [CoordW-1:0]   x_i,
  input  logic [CoordW-1:0]   w_i,
  input  logic [CoordW-1:0]   left_i,
  input  logic [CoordW-1:0]   right_i,
  output stat_t               stat_o,
  output logic [IdxOutW-1:0]  idx_o,
  output logic [LegalXW-1:0]  lx_o
);

  localparam int unsigned IdxW = $clog2(MaxCells);
  localparam int unsigned CntW = $clog2(MaxCells + 1);
  localparam int unsigned WsW  = CoordW + CntW;
  // offset sums go down by the running width sums of a full cluster
  localparam int unsigned OsW  = CoordW + 2 * CntW;
  localparam int unsigned PW   = WsW + FracBits + 3;
  localparam int unsigned NumW = OsW + FracBits;
  localparam int unsigned QW   = NumW + 1;

  logic [IdxW-1:0]          mem_first [MaxCells];
  logic [CntW-1:0]          mem_cnt   [MaxCells];
  logic signed [OsW-1:0]    mem_os    [MaxCells];
  logic [WsW-1:0]           mem_ws    [MaxCells];
  logic signed [PW-1:0]     mem_pos   [MaxCells];
  logic [CoordW-1:0]        mem_cw    [MaxCells];

  logic [CntW-1:0] total_q, total_d, depth_q, depth_d;

  // working copy of the top cluster
  logic [IdxW-1:0]       t_first_q, t_first_d;
  logic [CntW-1:0]       t_cnt_q, t_cnt_d;
  logic signed [OsW-1:0] t_os_q, t_os_d;
  logic [WsW-1:0]        t_ws_q, t_ws_d;
  logic signed [PW-1:0]  t_pos_q, t_pos_d;
  // previous cluster read
  logic [CntW-1:0]       p_cnt_q;
  logic signed [OsW-1:0] p_os_q;
  logic [WsW-1:0]        p_ws_q;
  logic signed [PW-1:0]  p_pos_q;
  logic [IdxW-1:0]       p_first_q;
  logic [CoordW-1:0]     cw_q;

  // divider
  logic [NumW-1:0]   rem_q, rem_d, quo_q, quo_d;
  logic [NumW-1:0]   dnum_q, dnum_d;
  logic              neg_q, neg_d;
  logic [$clog2(NumW+1)-1:0] dcnt_q, dcnt_d;
  logic              dbusy_q, dbusy_d;
  logic [NumW:0]     tr;

  logic signed [PW-1:0] start_fx, lo_fx, hi_fx, clamped, ep_q, ep_d;
  logic signed [QW-1:0] clamp_in, clamp_w;
  logic [IdxW-1:0]      k_q, k_d;
  logic signed [CoordW+2:0] sx;
  logic signed [PW-1:0]  rnd;
  logic signed [NumW-1:0] num_s;

  always_comb begin
    sx = $signed({3'b000, x_i});
    if (sx < $signed({3'b000, left_i})) sx = $signed({3'b000, left_i});
    if (sx > $signed({3'b000, right_i}) - $signed({3'b000, w_i}))
      sx = $signed({3'b000, right_i}) - $signed({3'b000, w_i});
    start_fx = PW'(sx) <<< FracBits;
  end

  // floor quotient and clamp at full quotient width, right bound wins
  always_comb begin
    lo_fx = $signed(PW'({left_i})) <<< FracBits;
    hi_fx = ($signed(PW'(right_i)) - $signed(PW'(t_ws_q))) <<< FracBits;
    clamp_in = neg_q ? -$signed({1'b0, quo_q}) - $signed({{NumW{1'b0}}, rem_q != '0})
                     : $signed({1'b0, quo_q});
    clamp_w = clamp_in;
    if (clamp_w < QW'(lo_fx)) clamp_w = QW'(lo_fx);
    if (clamp_w > QW'(hi_fx)) clamp_w = QW'(hi_fx);
    clamped = PW'(clamp_w);
  end

  assign stat_o.full        = (total_q == CntW'(MaxCells));
  assign stat_o.new_cluster = (depth_q == '0) ||
      (t_pos_q + ($signed(PW'(t_ws_q)) <<< FracBits) <= start_fx);
  assign stat_o.div_done    = !dbusy_q;
  assign stat_o.overlap     = (p_pos_q + ($signed(PW'(p_ws_q)) <<< FracBits) > t_pos_q);
  assign stat_o.at_bottom   = (depth_q == CntW'(1));
  assign stat_o.emit_last   = ({1'b0, k_q} + CntW'(1) == total_q);

  always_comb begin
    rnd = (ep_q + $signed(PW'(1 << FracBits >> 1))) >>> FracBits;
    if (rnd < -$signed(PW'(2097152))) lx_o = LegalXW'(-2097152);
    else if (rnd > $signed(PW'(2097151))) lx_o = LegalXW'(2097151);
    else lx_o = LegalXW'(rnd);
    idx_o = IdxOutW'(k_q);
  end

  always_comb begin
    total_d = total_q; depth_d = depth_q;
    t_first_d = t_first_q; t_cnt_d = t_cnt_q; t_os_d = t_os_q;
    t_ws_d = t_ws_q; t_pos_d = t_pos_q;
    rem_d = rem_q; quo_d = quo_q; dnum_d = dnum_q; neg_d = neg_q;
    dcnt_d = dcnt_q; dbusy_d = dbusy_q; ep_d = ep_q; k_d = k_q;
    num_s = NumW'(t_os_q) <<< FracBits;
    tr = {rem_q, dnum_q[NumW-1]} - (NumW+1)'(t_cnt_q);
    if (dbusy_q) begin
      // restoring division, one quotient bit a cycle
      dnum_d = dnum_q << 1;
      if (!tr[NumW]) begin
        rem_d = tr[NumW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[NumW-2:0], dnum_q[NumW-1]};
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      dcnt_d = dcnt_q - 1'b1;
      if (dcnt_q == 1) dbusy_d = 1'b0;
    end
    unique case (cmd_i)
      CmdClear: begin total_d = '0; depth_d = '0; end
      CmdInsert: begin
        total_d = total_q + 1'b1;
        if (stat_o.new_cluster) begin
          t_first_d = IdxW'(total_q); t_cnt_d = CntW'(1);
          t_os_d = OsW'($signed({1'b0, x_i}));
          t_ws_d = WsW'(w_i); t_pos_d = start_fx;
          depth_d = depth_q + 1'b1;
        end else begin
          t_cnt_d = t_cnt_q + 1'b1;
          t_os_d = t_os_q + OsW'($signed({1'b0, x_i})) - $signed(OsW'(t_ws_q));
          t_ws_d = t_ws_q + WsW'(w_i);
        end
      end
      CmdDivGo: begin
        neg_d = num_s[NumW-1];
        dnum_d = num_s[NumW-1] ? NumW'(-num_s) : NumW'(num_s);
        rem_d = '0; quo_d = '0; dcnt_d = ($clog2(NumW+1))'(NumW); dbusy_d = 1'b1;
      end
      CmdPlace: t_pos_d = clamped;
      CmdMerge: begin
        t_first_d = p_first_q;
        t_os_d = p_os_q + t_os_q - $signed(OsW'(t_cnt_q) * OsW'(p_ws_q));
        t_cnt_d = p_cnt_q + t_cnt_q;
        t_ws_d = p_ws_q + t_ws_q;
        t_pos_d = p_pos_q;
        depth_d = depth_q - 1'b1;
      end
      CmdEmitGo: begin k_d = t_first_q; ep_d = t_pos_q; end
      CmdEmitNx: begin
        k_d = k_q + 1'b1;
        ep_d = ep_q + ($signed(PW'(cw_q)) <<< FracBits);
      end
      default: ;
    endcase
  end

  // memory ports: top cluster write-back, reads of top, prev and cell width
  always_ff @(posedge clk_i) begin
    if (cmd_i == CmdInsert) mem_cw[IdxW'(total_q)] <= w_i;
    // a freshly opened cluster goes straight onto the stack
    if (cmd_i == CmdInsert && stat_o.new_cluster) begin
      mem_first[IdxW'(depth_q)] <= t_first_d;
      mem_cnt[IdxW'(depth_q)]   <= t_cnt_d;
      mem_os[IdxW'(depth_q)]    <= t_os_d;
      mem_ws[IdxW'(depth_q)]    <= t_ws_d;
      mem_pos[IdxW'(depth_q)]   <= t_pos_d;
    end
    if (cmd_i == CmdPlace) begin
      mem_first[IdxW'(depth_q - 1'b1)] <= t_first_q;
      mem_cnt[IdxW'(depth_q - 1'b1)]   <= t_cnt_q;
      mem_os[IdxW'(depth_q - 1'b1)]    <= t_os_q;
      mem_ws[IdxW'(depth_q - 1'b1)]    <= t_ws_q;
      mem_pos[IdxW'(depth_q - 1'b1)]   <= clamped;
    end
    if (cmd_i == CmdRdPrev) begin
      p_first_q <= mem_first[IdxW'(depth_q - 2'd2)];
      p_cnt_q   <= mem_cnt[IdxW'(depth_q - 2'd2)];
      p_os_q    <= mem_os[IdxW'(depth_q - 2'd2)];
      p_ws_q    <= mem_ws[IdxW'(depth_q - 2'd2)];
      p_pos_q   <= mem_pos[IdxW'(depth_q - 2'd2)];
    end
    cw_q <= mem_cw[k_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CmdRdTop) begin
      t_first_q <= mem_first[IdxW'(depth_q - 1'b1)];
      t_cnt_q   <= mem_cnt[IdxW'(depth_q - 1'b1)];
      t_os_q    <= mem_os[IdxW'(depth_q - 1'b1)];
      t_ws_q    <= mem_ws[IdxW'(depth_q - 1'b1)];
      t_pos_q   <= mem_pos[IdxW'(depth_q - 1'b1)];
    end else begin
      t_first_q <= t_first_d; t_cnt_q <= t_cnt_d; t_os_q <= t_os_d;
      t_ws_q <= t_ws_d; t_pos_q <= t_pos_d;
    end
    rem_q <= rem_d; quo_q <= quo_d; dnum_q <= dnum_d; neg_q <= neg_d;
    dcnt_q <= dcnt_d; ep_q <= ep_d; k_q <= k_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0; depth_q <= '0; dbusy_q <= 1'b0;
    end else begin
      total_q <= total_d; depth_q <= depth_d; dbusy_q <= dbusy_d;
    end
  end

endmodule

// File: rtl/arcp_ctrl.sv
// controller of the abacus row cluster placer: sequences insert,
// settle and emit; uses arcp_pkg
module arcp_ctrl import arcp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_kind_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output logic  out_full_o,
  output logic  out_last_o,
  input  stat_t stat_i,
  output cmd_e  cmd_o
);

  typedef enum logic [9:0] {
    StIdle  = 10'b0000000001,
    StRdTop = 10'b0000000010,
    StIns   = 10'b0000000100,
    StDiv   = 10'b0000001000,
    StWait  = 10'b0000010000,
    StPlace = 10'b0000100000,
    StRdPrv = 10'b0001000000,
    StCheck = 10'b0010000000,
    StEmit  = 10'b0100000000,
    StFull  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic go_q, go_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StEmit && !go_q) || (state_q == StFull);
  assign out_full_o  = (state_q == StFull);
  assign out_last_o  = (state_q == StFull) || stat_i.emit_last;

  always_comb begin
    state_d = state_q; cmd_o = CmdNone; go_d = 1'b0;
    unique case (state_q)
      StIdle: if (in_valid_i) begin
        if (in_kind_i == KindClear) cmd_o = CmdClear;
        else if (stat_i.full) state_d = StFull;
        else state_d = StIns;
      end
      StRdTop: begin cmd_o = CmdRdTop; state_d = StDiv; end
      StIns: begin
        cmd_o = CmdInsert;
        if (stat_i.new_cluster) begin state_d = StEmit; go_d = 1'b1; end
        else state_d = StDiv;
      end
      StDiv: begin cmd_o = CmdDivGo; state_d = StWait; end
      StWait: if (stat_i.div_done) state_d = StPlace;
      StPlace: begin
        cmd_o = CmdPlace;
        if (stat_i.at_bottom) begin state_d = StEmit; go_d = 1'b1; end
        else state_d = StRdPrv;
      end
      StRdPrv: begin cmd_o = CmdRdPrev; state_d = StCheck; end
      StCheck: begin
        if (stat_i.overlap) begin cmd_o = CmdMerge; state_d = StDiv; end
        else begin state_d = StEmit; go_d = 1'b1; end
      end
      StEmit: begin
        if (go_q) cmd_o = CmdEmitGo;
        else if (out_ready_i) begin
          if (stat_i.emit_last) state_d = StIdle;
          else cmd_o = CmdEmitNx;
        end
      end
      StFull: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; go_q <= 1'b0;
    end else begin
      state_q <= state_d; go_q <= go_d;
    end
  end

endmodule

// File: rtl/abacus_row_cluster_placer_top.sv
// top level of the abacus row cluster placer
// joins arcp_ctrl and arcp_datapath; uses arcp_pkg
//
// abacus legalization of one subrow. kind 0 clears the subrow, kind 1 adds a
// cell (cells in rising x). each add gives one transfer per cell of the last
// cluster (index, rounded x, tlast on the final one), or a single full-status
// transfer when the subrow already holds MaxCells cells. one item at a time:
// an add passes accept, insert and emit setup before its first result, then
// one result per cycle when the sink is ready. a cell that joins a cluster
// adds a settle round per merge step (divide start, divider wait, place,
// previous cluster read, overlap check; place ends it at the bottom cluster),
// paced by the bit-serial divider (NumW = 34+FracBits at defaults, 1 quotient bit a cycle).
module abacus_row_cluster_placer_top import arcp_pkg::*; #(
  parameter int unsigned MaxCells = MaxCellsDef,
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CoordW-1:0]   cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,   // cell_x, cell_width
  input  logic                s_axis_tuser,   // kind
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,   // cell_index, legal_x, zero fill
  output logic                m_axis_tuser,   // status
  output logic                m_axis_tlast
);

  logic [CoordW-1:0] left_q, right_q;
  logic [CoordW-1:0] cell_x_q, cell_w_q;
  cmd_e  cmd;
  stat_t stat;
  logic [IdxOutW-1:0] idx;
  logic [LegalXW-1:0] lx;
  logic full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0; right_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSubrowLeft:  left_q  <= cfg_data_i;
        CfgSubrowRight: right_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // hold the accepted cell for the insert step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_x_q <= '0; cell_w_q <= '0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      cell_x_q <= s_axis_tdata[19:0];
      cell_w_q <= s_axis_tdata[39:20];
    end
  end

  arcp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_kind_i(s_axis_tuser), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_full_o(full), .out_last_o(m_axis_tlast),
    .stat_i(stat), .cmd_o(cmd)
  );

  arcp_datapath #(.MaxCells(MaxCells), .FracBits(FracBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .x_i(cell_x_q), .w_i(cell_w_q),
    .left_i(left_q), .right_i(right_q),
    .stat_o(stat), .idx_o(idx), .lx_o(lx)
  );

  // full status carries index 0 and x 0
  assign m_axis_tdata = full ? 32'd0 : {4'd0, lx, idx};
  assign m_axis_tuser = full;

  // a full-status transfer is always the last of its item
  a_full_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("full status without tlast");
  // no new input while results are pending
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while output pending");

endmodule
